@@ rtl/triangle_tile_binner_defines.svh @@
// ----------------------------------------------------------------------------
// triangle tile binner assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TILE_BINNER_DEFINES_SVH
`define TRIANGLE_TILE_BINNER_DEFINES_SVH

// condition in one cycle implies a condition in the next
`define TTB_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("ttb: next cycle check failed");

// condition in one cycle implies the signal holds into the next
`define TTB_ASSERT_STABLE(lbl, clk, dis, ante, sig) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> $stable(sig)) \
        else $error("ttb: signal changed while held");

`endif

@@ rtl/ttb_pkg.sv @@
// ----------------------------------------------------------------------------
// ttb_pkg
// types and fixed widths shared by the triangle tile binner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ttb_pkg;

    localparam int COORD_W    = 16;
    localparam int TAG_W      = 16;
    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 32;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 10;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 11;
    localparam int PIX_W      = 11;
    localparam int TILE_CW    = 8;
    localparam int TOTAL_W    = 7;
    localparam int IDX_W      = 6;
    localparam int TOUT_W     = 3;
    localparam int RESULT_CAP = 64;

    localparam logic [CFG_ADDR_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

    localparam logic [WIDTH_W-1:0]  SCREEN_WIDTH_RST  = 11'd1024;
    localparam logic [HEIGHT_W-1:0] SCREEN_HEIGHT_RST = 10'd512;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_GEOM,
        FS_DIV,
        FS_LIM,
        FS_PUSH
    } front_state_t;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [TILE_CW-1:0] tx0;
        logic [TILE_CW-1:0] xlim;
        logic [TILE_CW-1:0] ty0;
        logic [TILE_CW-1:0] ylim;
        logic [TILE_CW-1:0] wt;
        logic [IDX_W-1:0]   row_base;
        logic [TOTAL_W-1:0] total;
    } bin_job_t;

endpackage

@@ rtl/ttb_cdiv.sv @@
// ----------------------------------------------------------------------------
// ttb_cdiv
// unsigned division by a fixed divisor through a rounded-up reciprocal
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttb_cdiv #(
    parameter int DIVISOR = 128,
    parameter int N       = 11,
    parameter int QW      = 8
) (
    input  logic [N-1:0]  dividend,
    output logic [QW-1:0] quotient
);

    localparam int C  = $clog2(DIVISOR);
    localparam int S  = N + C;
    localparam int MW = N + 2;
    localparam int PW = N + MW;
    localparam int M  = ((1 << S) + DIVISOR - 1) / DIVISOR;

    logic [PW-1:0] prod;

    assign prod     = PW'(dividend) * PW'(M);
    assign quotient = QW'(prod >> S);

endmodule

@@ rtl/ttb_queue.sv @@
// ----------------------------------------------------------------------------
// ttb_queue
// short first-in first-out queue between the front and back parts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttb_queue #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/ttb_front.sv @@
// ----------------------------------------------------------------------------
// ttb_front
// takes a triangle, works out its tile range and drops it if back-facing or empty
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttb_front #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 512,
    parameter int TILE_WIDTH  = 128,
    parameter int TILE_HEIGHT = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ttb_pkg::IN_DATA_W-1:0]  s_tdata,
    input  logic [ttb_pkg::WIDTH_W-1:0]    screen_width,
    input  logic [ttb_pkg::HEIGHT_W-1:0]   screen_height,
    output logic                           job_valid,
    input  logic                           job_ready,
    output ttb_pkg::bin_job_t              job
);

    import ttb_pkg::*;

    localparam int PROD_W = 2 * COORD_W + 2;
    localparam int MAG_W  = COORD_W + 1;

    front_state_t state_reg, state_next;
    logic         capture;

    // vertex and tag capture
    logic signed [COORD_W-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic [TAG_W-1:0]          tag_reg;

    // geometry stage
    logic signed [COORD_W:0]   d31x, d31y, d21x, d21y;
    logic signed [PROD_W-1:0]  prod1_reg, prod2_reg;
    logic signed [COORD_W-1:0] minx, miny, maxx, maxy;
    logic [WIDTH_W-1:0]        wc_next, wc_reg;
    logic [HEIGHT_W-1:0]       hc_next, hc_reg;
    logic [COORD_W-2:0]        wlim, hlim, maxx_cl, maxy_cl;
    logic [MAG_W-1:0]          xmag, ymag;
    logic [PIX_W-1:0]          px0_next, py0_next, px1_next, py1_next;
    logic [PIX_W-1:0]          px0_reg, py0_reg, px1_reg, py1_reg;
    logic                      xoff_next, yoff_next, xoff_reg, yoff_reg;

    // division stage
    logic [TILE_CW-1:0] tx0_q, ty0_q, xl_q, yl_q, wt_q, ht_q;
    logic [TILE_CW-1:0] tx0_reg, ty0_reg, xl_reg, yl_reg, wt_reg, ht_reg;
    logic               xoff2_reg, yoff2_reg, cull_reg;

    // limit stage
    logic [TILE_CW-1:0]   xlim, ylim, cols, rows;
    logic [2*TILE_CW-1:0] area, base_prod;
    logic                 empty;
    bin_job_t             job_next, job_reg;
    logic                 drop_next, drop_reg;

    function automatic logic signed [COORD_W-1:0] min3(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b,
        input logic signed [COORD_W-1:0] c
    );
        logic signed [COORD_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [COORD_W-1:0] max3(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b,
        input logic signed [COORD_W-1:0] c
    );
        logic signed [COORD_W-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        job_valid  = 1'b0;
        case (state_reg)
            FS_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = FS_GEOM;
                end
            end
            FS_GEOM: state_next = FS_DIV;
            FS_DIV:  state_next = FS_LIM;
            FS_LIM:  state_next = FS_PUSH;
            FS_PUSH: begin
                job_valid = !drop_reg;
                if (drop_reg || job_ready) begin
                    s_tready   = 1'b1;
                    state_next = s_tvalid ? FS_GEOM : FS_IDLE;
                end
            end
            default: state_next = FS_IDLE;
        endcase
    end

    assign capture = s_tvalid && s_tready;
    assign job     = job_reg;

    always_ff @(posedge aclk) begin
        if (capture) begin
            ax_reg  <= s_tdata[0*COORD_W +: COORD_W];
            ay_reg  <= s_tdata[1*COORD_W +: COORD_W];
            bx_reg  <= s_tdata[2*COORD_W +: COORD_W];
            by_reg  <= s_tdata[3*COORD_W +: COORD_W];
            cx_reg  <= s_tdata[4*COORD_W +: COORD_W];
            cy_reg  <= s_tdata[5*COORD_W +: COORD_W];
            tag_reg <= s_tdata[6*COORD_W +: TAG_W];
        end
    end

    // signed area terms, bounding box, clamping
    always_comb begin
        d31x = (COORD_W+1)'(cx_reg) - (COORD_W+1)'(ax_reg);
        d31y = (COORD_W+1)'(cy_reg) - (COORD_W+1)'(ay_reg);
        d21x = (COORD_W+1)'(bx_reg) - (COORD_W+1)'(ax_reg);
        d21y = (COORD_W+1)'(by_reg) - (COORD_W+1)'(ay_reg);

        minx = min3(ax_reg, bx_reg, cx_reg);
        miny = min3(ay_reg, by_reg, cy_reg);
        maxx = max3(ax_reg, bx_reg, cx_reg);
        maxy = max3(ay_reg, by_reg, cy_reg);

        if (screen_width == '0) begin
            wc_next = WIDTH_W'(1);
        end else if (screen_width > WIDTH_W'(MAX_WIDTH)) begin
            wc_next = WIDTH_W'(MAX_WIDTH);
        end else begin
            wc_next = screen_width;
        end
        if (screen_height == '0) begin
            hc_next = HEIGHT_W'(1);
        end else if (screen_height > HEIGHT_W'(MAX_HEIGHT)) begin
            hc_next = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            hc_next = screen_height;
        end

        wlim    = {(COORD_W-1-WIDTH_W)'(0), wc_next} << 4;
        hlim    = {(COORD_W-1-HEIGHT_W)'(0), hc_next} << 4;
        maxx_cl = (maxx[COORD_W-2:0] > wlim) ? wlim : maxx[COORD_W-2:0];
        maxy_cl = (maxy[COORD_W-2:0] > hlim) ? hlim : maxy[COORD_W-2:0];

        px0_next = minx[COORD_W-1] ? '0 : minx[COORD_W-2:4];
        py0_next = miny[COORD_W-1] ? '0 : miny[COORD_W-2:4];
        px1_next = maxx[COORD_W-1] ? '0 : maxx_cl[COORD_W-2:4];
        py1_next = maxy[COORD_W-1] ? '0 : maxy_cl[COORD_W-2:4];

        // negative maximum: off screen only once a whole tile lies below zero
        xmag      = MAG_W'(0) - MAG_W'(maxx);
        ymag      = MAG_W'(0) - MAG_W'(maxy);
        xoff_next = maxx[COORD_W-1] && (xmag[MAG_W-1:4] >= (MAG_W-4)'(TILE_WIDTH));
        yoff_next = maxy[COORD_W-1] && (ymag[MAG_W-1:4] >= (MAG_W-4)'(TILE_HEIGHT));
    end

    always_ff @(posedge aclk) begin
        if (state_reg == FS_GEOM) begin
            prod1_reg <= PROD_W'(d31x * d21y);
            prod2_reg <= PROD_W'(d31y * d21x);
            wc_reg    <= wc_next;
            hc_reg    <= hc_next;
            px0_reg   <= px0_next;
            py0_reg   <= py0_next;
            px1_reg   <= px1_next;
            py1_reg   <= py1_next;
            xoff_reg  <= xoff_next;
            yoff_reg  <= yoff_next;
        end
    end

    // tile division
    ttb_cdiv #(.DIVISOR(TILE_WIDTH), .N(PIX_W), .QW(TILE_CW)) u_div_tx0 (
        .dividend (px0_reg),
        .quotient (tx0_q)
    );

    ttb_cdiv #(.DIVISOR(TILE_HEIGHT), .N(PIX_W), .QW(TILE_CW)) u_div_ty0 (
        .dividend (py0_reg),
        .quotient (ty0_q)
    );

    ttb_cdiv #(.DIVISOR(TILE_WIDTH), .N(PIX_W), .QW(TILE_CW)) u_div_xl (
        .dividend (px1_reg),
        .quotient (xl_q)
    );

    ttb_cdiv #(.DIVISOR(TILE_HEIGHT), .N(PIX_W), .QW(TILE_CW)) u_div_yl (
        .dividend (py1_reg),
        .quotient (yl_q)
    );

    ttb_cdiv #(.DIVISOR(TILE_WIDTH), .N(PIX_W), .QW(TILE_CW)) u_div_wt (
        .dividend (PIX_W'(wc_reg) + PIX_W'(TILE_WIDTH - 1)),
        .quotient (wt_q)
    );

    ttb_cdiv #(.DIVISOR(TILE_HEIGHT), .N(PIX_W), .QW(TILE_CW)) u_div_ht (
        .dividend (PIX_W'(hc_reg) + PIX_W'(TILE_HEIGHT - 1)),
        .quotient (ht_q)
    );

    always_ff @(posedge aclk) begin
        if (state_reg == FS_DIV) begin
            tx0_reg   <= tx0_q;
            ty0_reg   <= ty0_q;
            xl_reg    <= xl_q;
            yl_reg    <= yl_q;
            wt_reg    <= wt_q;
            ht_reg    <= ht_q;
            xoff2_reg <= xoff_reg;
            yoff2_reg <= yoff_reg;
            cull_reg  <= (prod1_reg < prod2_reg);
        end
    end

    // tile limits, count and index of the first tile
    always_comb begin
        xlim      = (xl_reg > wt_reg - 1'b1) ? wt_reg - 1'b1 : xl_reg;
        ylim      = (yl_reg > ht_reg - 1'b1) ? ht_reg - 1'b1 : yl_reg;
        empty     = xoff2_reg || yoff2_reg || (tx0_reg > xlim) || (ty0_reg > ylim);
        cols      = xlim - tx0_reg + 1'b1;
        rows      = ylim - ty0_reg + 1'b1;
        area      = (2*TILE_CW)'(cols) * (2*TILE_CW)'(rows);
        base_prod = (2*TILE_CW)'(ty0_reg) * (2*TILE_CW)'(wt_reg)
                  + (2*TILE_CW)'(tx0_reg);

        job_next.tag      = tag_reg;
        job_next.tx0      = tx0_reg;
        job_next.xlim     = xlim;
        job_next.ty0      = ty0_reg;
        job_next.ylim     = ylim;
        job_next.wt       = wt_reg;
        job_next.row_base = base_prod[IDX_W-1:0];
        job_next.total    = (area > (2*TILE_CW)'(RESULT_CAP)) ? TOTAL_W'(RESULT_CAP)
                                                              : area[TOTAL_W-1:0];
        drop_next         = cull_reg || empty;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == FS_LIM) begin
            job_reg  <= job_next;
            drop_reg <= drop_next;
        end
    end

endmodule

@@ rtl/ttb_back.sv @@
// ----------------------------------------------------------------------------
// ttb_back
// walks the tile range of one request in row-major order, one tile a beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttb_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           job_valid,
    output logic                           job_ready,
    input  ttb_pkg::bin_job_t              job,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ttb_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tlast
);

    import ttb_pkg::*;

    bin_job_t           job_reg;
    logic [TILE_CW-1:0] tx_reg, ty_reg;
    logic [TOTAL_W-1:0] n_reg;
    logic [IDX_W-1:0]   idx_reg, row_idx_reg, row_next_idx;
    logic               valid_reg;
    logic               last_w, load, step;

    assign last_w       = (n_reg == job_reg.total - 1'b1);
    assign job_ready    = !valid_reg || (m_tready && last_w);
    assign load         = job_valid && job_ready;
    assign step         = valid_reg && m_tready && !last_w;
    assign row_next_idx = row_idx_reg + job_reg.wt[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (valid_reg && m_tready && last_w) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            job_reg     <= job;
            tx_reg      <= job.tx0;
            ty_reg      <= job.ty0;
            n_reg       <= '0;
            idx_reg     <= job.row_base;
            row_idx_reg <= job.row_base;
        end else if (step) begin
            n_reg <= n_reg + 1'b1;
            if (tx_reg == job_reg.xlim) begin
                tx_reg      <= job_reg.tx0;
                ty_reg      <= ty_reg + 1'b1;
                row_idx_reg <= row_next_idx;
                idx_reg     <= row_next_idx;
            end else begin
                tx_reg  <= tx_reg + 1'b1;
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last_w;
    assign m_tdata  = {(OUT_DATA_W-IDX_W-2*TOUT_W-TAG_W)'(0), job_reg.tag,
                       ty_reg[TOUT_W-1:0], tx_reg[TOUT_W-1:0], idx_reg};

endmodule

@@ rtl/triangle_tile_binner.sv @@
// triangle tile binner: a request goes through the front stages, queue and back
// the front takes a new triangle once the last is pushed to the queue or dropped
// the back emits one tile per cycle while m_tready is high
// queue of two requests lets front and back stall independently
// synchronous active-low reset: sizes return to 1024 x 512, queue and output empty
// ----------------------------------------------------------------------------
// triangle_tile_binner
// bins screen-space triangles into the tiles their bounding box covers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_tile_binner #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HEIGHT  = 512,
    parameter int TILE_WIDTH  = 128,
    parameter int TILE_HEIGHT = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // v0_x, v0_y, v1_x, v1_y, v2_x, v2_y, face_tag
    input  logic [ttb_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // tile_index, tile_col, tile_row, tag_out, zero pad
    output logic [ttb_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic                            m_tlast,
    input  logic                            cfg_wr_en,
    input  logic [ttb_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [ttb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    import ttb_pkg::*;

    logic [WIDTH_W-1:0]  screen_width_reg;
    logic [HEIGHT_W-1:0] screen_height_reg;
    bin_job_t            push_job, pop_job;
    logic                push_valid, push_ready, pop_valid, pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= SCREEN_WIDTH_RST;
            screen_height_reg <= SCREEN_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_wdata[WIDTH_W-1:0];
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_wdata[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    ttb_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .TILE_WIDTH  (TILE_WIDTH),
        .TILE_HEIGHT (TILE_HEIGHT)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .job_valid     (push_valid),
        .job_ready     (push_ready),
        .job           (push_job)
    );

    ttb_queue #(
        .WIDTH ($bits(bin_job_t)),
        .DEPTH (2)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_job)
    );

    ttb_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (pop_valid),
        .job_ready (pop_ready),
        .job       (pop_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

@@ rtl/ttb_checker.sv @@
// ----------------------------------------------------------------------------
// ttb_checker
// port-level checks for the triangle tile binner, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "triangle_tile_binner_defines.svh"

module ttb_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ttb_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic                            m_tlast
);

    `TTB_ASSERT_NEXT(a_m_valid_hold, aclk, !aresetn, m_tvalid && !m_tready, m_tvalid)
    `TTB_ASSERT_STABLE(a_m_data_hold, aclk, !aresetn, m_tvalid && !m_tready, {m_tdata, m_tlast})
    `TTB_ASSERT_NEXT(a_accept_busy, aclk, !aresetn, s_tvalid && s_tready, !s_tready)
    `TTB_ASSERT_NEXT(a_reset_out_idle, aclk, 1'b0, !aresetn, !m_tvalid)
    `TTB_ASSERT_NEXT(a_reset_in_ready, aclk, 1'b0, !aresetn, s_tready)

endmodule

bind triangle_tile_binner ttb_checker u_ttb_checker (.*);
